/* hdl/mmdp_pkg.sv */
// ----------------------------------------------------------------------------
// mmdp_pkg
// Shared widths, constants and types of the min/max decimation pyramid.
// ----------------------------------------------------------------------------
package mmdp_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int LEVEL_W        = 4;
  localparam int INDEX_W        = 15;
  localparam int CNT_W          = 16;
  localparam int DEF_MAX_LEVELS = 16;

  typedef logic signed [SAMPLE_W-1:0] smp_t;

  // carry travelling up the row of level cells
  typedef struct packed {
    logic v;
    logic carry;
    logic fin;
    smp_t cmin;
    smp_t cmax;
  } tok_t;

  // per-cell status towards the top level
  typedef struct packed {
    logic               done;
    logic               emit;
    logic [LEVEL_W-1:0] level;
    logic [INDEX_W-1:0] idx;
    smp_t               bmin;
    smp_t               bmax;
  } cell_sts_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [INDEX_W-1:0] bucket_idx;
    smp_t               bucket_min;
    smp_t               bucket_max;
    logic               no_levels;
    logic               overflowed;
    logic               last_result;
  } res_t;

endpackage

/* hdl/mmdp_in_if.sv */
// ----------------------------------------------------------------------------
// mmdp_in_if
// Sample channel: valid/ready handshake with sample and end marker.
// ----------------------------------------------------------------------------
interface mmdp_in_if import mmdp_pkg::*; ();

  logic valid;
  logic ready;
  smp_t sample;
  logic end_of_signal;

  modport source (output valid, output sample, output end_of_signal, input ready);
  modport sink   (input valid, input sample, input end_of_signal, output ready);

endinterface

/* hdl/mmdp_out_if.sv */
// ----------------------------------------------------------------------------
// mmdp_out_if
// Bucket channel: valid/ready handshake with one pyramid result.
// ----------------------------------------------------------------------------
interface mmdp_out_if import mmdp_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level;
  logic [INDEX_W-1:0] bucket_idx;
  smp_t               bucket_min;
  smp_t               bucket_max;
  logic               no_levels;
  logic               overflowed;
  logic               last_result;

  modport source (
    output valid, output level, output bucket_idx, output bucket_min,
    output bucket_max, output no_levels, output overflowed, output last_result,
    input ready
  );
  modport sink (
    input valid, input level, input bucket_idx, input bucket_min,
    input bucket_max, input no_levels, input overflowed, input last_result,
    output ready
  );

endinterface

/* hdl/min_max_decimation_pyramid_unit.sv */
// ----------------------------------------------------------------------------
// min_max_decimation_pyramid_unit
// Streaming min/max level-of-detail pyramid built from a row of level cells.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  in_chan   sink       sample, end_of_signal
//  out_chan  source     level, bucket_idx, bucket_min, bucket_max,
//                       no_levels, overflowed, last_result
//
//  A sample is accepted in ST_IDLE; in ST_WALK the carry visits the level cells
//  (1 to MAX_LEVELS), one cell per cycle unless output back-pressure holds a
//  bucket, and ST_FLUSH releases the last bucket. A new sample is taken only
//  once the unit is back in ST_IDLE.
//  rst_n is synchronous; after it, and after every end of signal, all levels
//  are empty and the counts are zero.
// ----------------------------------------------------------------------------
module min_max_decimation_pyramid_unit import mmdp_pkg::*; #(
  parameter int MAX_LEVELS = DEF_MAX_LEVELS
) (
  input logic        clk,
  input logic        rst_n,
  mmdp_in_if.sink    in_chan,
  mmdp_out_if.source out_chan
);

  localparam int SCNT_W = MAX_LEVELS + 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [SCNT_W-1:0] scnt_r, scnt_nxt;
  logic              ovf_r, ovf_nxt;
  logic              fin_r, fin_nxt;
  logic              hold_v_r, hold_v_nxt;
  res_t              hold_r, hold_nxt;
  logic              out_v_r, out_v_nxt;
  res_t              out_r, out_nxt;

  tok_t      tok_c   [MAX_LEVELS+1];
  logic      below_c [MAX_LEVELS+1];
  cell_sts_t sts     [MAX_LEVELS];

  logic      clr, go, out_free, out_load, walk_end, em;
  tok_t      tok_in;
  cell_sts_t em_sts;

  assign out_free   = !out_v_r || out_chan.ready;
  assign go         = !hold_v_r || out_free;
  assign below_c[0] = (scnt_r[SCNT_W-1:1] == '0);
  assign tok_c[0]   = tok_in;

  for (genvar k = 0; k < MAX_LEVELS; k++) begin : g_cell
    mmdp_cell #(
      .LVL (k)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .clr     (clr),
      .go      (go),
      .below_i (below_c[k]),
      .tok_i   (tok_c[k]),
      .tok_o   (tok_c[k+1]),
      .below_o (below_c[k+1]),
      .sts_o   (sts[k])
    );
  end

  // only one cell holds the carry, so an or of the gated status is a select
  always_comb begin
    em_sts   = '0;
    walk_end = tok_c[MAX_LEVELS].v;
    for (int k = 0; k < MAX_LEVELS; k++) begin
      walk_end = walk_end | sts[k].done;
      if (sts[k].emit) begin
        em_sts = em_sts | sts[k];
      end
    end
    em = em_sts.emit;
  end

  always_comb begin
    state_nxt  = state_r;
    scnt_nxt   = scnt_r;
    ovf_nxt    = ovf_r;
    fin_nxt    = fin_r;
    hold_v_nxt = hold_v_r;
    hold_nxt   = hold_r;
    out_nxt    = out_r;
    out_load   = 1'b0;
    clr        = 1'b0;
    tok_in     = '0;

    in_chan.ready = (state_r == ST_IDLE);

    if (em) begin
      hold_v_nxt            = 1'b1;
      hold_nxt.level        = em_sts.level;
      hold_nxt.bucket_idx   = em_sts.idx;
      hold_nxt.bucket_min   = em_sts.bmin;
      hold_nxt.bucket_max   = em_sts.bmax;
      hold_nxt.no_levels    = 1'b0;
      hold_nxt.overflowed   = ovf_r;
      hold_nxt.last_result  = 1'b0;
      if (hold_v_r) begin
        out_load = 1'b1;
        out_nxt  = hold_r;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          fin_nxt     = in_chan.end_of_signal;
          tok_in.v    = 1'b1;
          tok_in.fin  = in_chan.end_of_signal;
          tok_in.cmin = in_chan.sample;
          tok_in.cmax = in_chan.sample;
          // capacity reached: drop the sample but still run the end flush
          if (scnt_r[SCNT_W-1]) begin
            ovf_nxt = 1'b1;
          end else begin
            scnt_nxt     = scnt_r + SCNT_W'(1);
            tok_in.carry = 1'b1;
          end
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_end) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!hold_v_r && !fin_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_load = 1'b1;
          if (hold_v_r) begin
            out_nxt             = hold_r;
            out_nxt.last_result = fin_r;
            hold_v_nxt          = 1'b0;
          end else begin
            // no bucket came out of the end step
            out_nxt             = '0;
            out_nxt.no_levels   = below_c[0];
            out_nxt.overflowed  = ovf_r;
            out_nxt.last_result = 1'b1;
          end
          if (fin_r) begin
            clr      = 1'b1;
            scnt_nxt = '0;
            ovf_nxt  = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_v_nxt = (out_v_r && !out_chan.ready) || out_load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      scnt_r   <= '0;
      ovf_r    <= 1'b0;
      fin_r    <= 1'b0;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      scnt_r   <= scnt_nxt;
      ovf_r    <= ovf_nxt;
      fin_r    <= fin_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

  assign out_chan.valid        = out_v_r;
  assign out_chan.level        = out_r.level;
  assign out_chan.bucket_idx   = out_r.bucket_idx;
  assign out_chan.bucket_min   = out_r.bucket_min;
  assign out_chan.bucket_max   = out_r.bucket_max;
  assign out_chan.no_levels    = out_r.no_levels;
  assign out_chan.overflowed   = out_r.overflowed;
  assign out_chan.last_result  = out_r.last_result;

endmodule

/* hdl/mmdp_cell.sv */
// ----------------------------------------------------------------------------
// mmdp_cell
// One pyramid level: holds the unpaired bucket and the bucket count of its
// level, pairs the incoming carry and hands the result to the next level.
// ----------------------------------------------------------------------------
module mmdp_cell import mmdp_pkg::*; #(
  parameter int LVL = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      clr,
  input  logic      go,
  input  logic      below_i,
  input  tok_t      tok_i,
  output tok_t      tok_o,
  output logic      below_o,
  output cell_sts_t sts_o
);

  logic             tok_v_r, tok_v_nxt;
  logic             tk_carry_r, tk_carry_nxt;
  logic             tk_fin_r, tk_fin_nxt;
  smp_t             tk_min_r, tk_min_nxt;
  smp_t             tk_max_r, tk_max_nxt;
  logic             pend_v_r, pend_v_nxt;
  smp_t             pend_min_r, pend_min_nxt;
  smp_t             pend_max_r, pend_max_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic pair, lone, emit, stop, act;
  smp_t mrg_min, mrg_max, lone_min, lone_max, res_min, res_max;

  always_comb begin
    mrg_min  = (pend_min_r < tk_min_r) ? pend_min_r : tk_min_r;
    mrg_max  = (pend_max_r > tk_max_r) ? pend_max_r : tk_max_r;
    lone_min = tk_carry_r ? tk_min_r : pend_min_r;
    lone_max = tk_carry_r ? tk_max_r : pend_max_r;

    pair = tk_carry_r && pend_v_r;
    // unpaired carry, or the waiting bucket released at end of signal
    lone = !pair && (tk_carry_r || (tk_fin_r && pend_v_r));
    emit = pair || (lone && tk_fin_r && !below_i);
    stop = (lone && (!tk_fin_r || below_i)) || (!pair && !lone && !tk_fin_r);
    act  = tok_v_r && (go || !emit);

    res_min = pair ? mrg_min : lone_min;
    res_max = pair ? mrg_max : lone_max;

    tok_v_nxt    = tok_v_r;
    tk_carry_nxt = tk_carry_r;
    tk_fin_nxt   = tk_fin_r;
    tk_min_nxt   = tk_min_r;
    tk_max_nxt   = tk_max_r;
    pend_v_nxt   = pend_v_r;
    pend_min_nxt = pend_min_r;
    pend_max_nxt = pend_max_r;
    cnt_nxt      = cnt_r;

    if (tok_i.v) begin
      tok_v_nxt    = 1'b1;
      tk_carry_nxt = tok_i.carry;
      tk_fin_nxt   = tok_i.fin;
      tk_min_nxt   = tok_i.cmin;
      tk_max_nxt   = tok_i.cmax;
    end else if (act) begin
      tok_v_nxt = 1'b0;
    end

    if (act) begin
      if (pair) begin
        pend_v_nxt = 1'b0;
      end else if (lone) begin
        if (!tk_fin_r) begin
          pend_v_nxt   = 1'b1;
          pend_min_nxt = lone_min;
          pend_max_nxt = lone_max;
        end else begin
          pend_v_nxt = 1'b0;
        end
      end
      if (emit) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end

    if (clr) begin
      tok_v_nxt  = 1'b0;
      pend_v_nxt = 1'b0;
      cnt_nxt    = '0;
    end

    tok_o.v     = act && !stop;
    tok_o.carry = pair || lone;
    tok_o.fin   = tk_fin_r;
    tok_o.cmin  = res_min;
    tok_o.cmax  = res_max;

    sts_o.done  = act && stop;
    sts_o.emit  = act && emit;
    sts_o.level = LEVEL_W'(LVL);
    sts_o.idx   = cnt_r[INDEX_W-1:0];
    sts_o.bmin  = res_min;
    sts_o.bmax  = res_max;

    below_o = (cnt_r[CNT_W-1:1] == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      tok_v_r  <= tok_v_nxt;
      pend_v_r <= pend_v_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tk_carry_r <= tk_carry_nxt;
    tk_fin_r   <= tk_fin_nxt;
    tk_min_r   <= tk_min_nxt;
    tk_max_r   <= tk_max_nxt;
    pend_min_r <= pend_min_nxt;
    pend_max_r <= pend_max_nxt;
  end

endmodule
